[rtl/core/assert_macros.svh]
// Assertion macros shared by the polynomial multiplier RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/polymul_pkg.sv]
// Types, codes and microcode table of the polynomial multiplier.
package polymul_pkg;

   localparam logic [1:0] OP_LOAD_P = 2'd0;
   localparam logic [1:0] OP_LOAD_Q = 2'd1;
   localparam logic [1:0] OP_START  = 2'd2;

   localparam int STEP_W = 3;
   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_IDLE = 3'd0;
   localparam step_type STEP_RD   = 3'd1;
   localparam step_type STEP_MUL  = 3'd2;
   localparam step_type STEP_ACC  = 3'd3;
   localparam step_type STEP_ORD  = 3'd4;
   localparam step_type STEP_WAIT = 3'd5;
   localparam step_type STEP_EMIT = 3'd6;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_START,
      COND_MAC_DONE,
      COND_OUT_BUSY,
      COND_LAST
   } cond_type;

   typedef struct packed {
      logic     ready;
      logic     rd;
      logic     mul;
      logic     acc;
      logic     ord;
      logic     emit;
      cond_type cond;
      step_type target;
      step_type next;
   } ucode_type;

   typedef struct packed {
      logic start;
      logic mac_done;
      logic out_busy;
      logic out_last;
   } stat_type;

   localparam logic signed [63:0] SAT_MAX = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] SAT_MIN = {1'b1, {63{1'b0}}};

   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type w;
      w = '{ready: 1'b0, rd: 1'b0, mul: 1'b0, acc: 1'b0, ord: 1'b0, emit: 1'b0,
            cond: COND_NEVER, target: STEP_IDLE, next: STEP_IDLE};
      unique case (step)
         STEP_IDLE: begin
            w.ready = 1'b1; w.cond = COND_START; w.target = STEP_RD; w.next = STEP_IDLE;
         end
         STEP_RD: begin
            w.rd = 1'b1; w.next = STEP_MUL;
         end
         STEP_MUL: begin
            w.mul = 1'b1; w.next = STEP_ACC;
         end
         STEP_ACC: begin
            w.acc = 1'b1; w.cond = COND_MAC_DONE; w.target = STEP_ORD; w.next = STEP_RD;
         end
         STEP_ORD: begin
            w.ord = 1'b1; w.next = STEP_WAIT;
         end
         STEP_WAIT: begin
            w.cond = COND_OUT_BUSY; w.target = STEP_WAIT; w.next = STEP_EMIT;
         end
         STEP_EMIT: begin
            w.emit = 1'b1; w.cond = COND_LAST; w.target = STEP_IDLE; w.next = STEP_ORD;
         end
         default: begin
            w.next = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

[rtl/core/polymul_useq.sv]
// Microcode sequencer: step counter, control store and conditional jumps.
module polymul_useq (
   input  logic                   clock,
   input  logic                   reset,
   input  polymul_pkg::stat_type  stat,
   output polymul_pkg::ucode_type ctrl
);

   polymul_pkg::step_type step_ff;
   polymul_pkg::step_type step_in;
   logic                  take;

   always_comb begin
      ctrl = polymul_pkg::ucode_rom(step_ff);
      unique case (ctrl.cond)
         polymul_pkg::COND_NEVER:    take = 1'b0;
         polymul_pkg::COND_START:    take = stat.start;
         polymul_pkg::COND_MAC_DONE: take = stat.mac_done;
         polymul_pkg::COND_OUT_BUSY: take = stat.out_busy;
         polymul_pkg::COND_LAST:     take = stat.out_last;
         default:                    take = 1'b0;
      endcase
      step_in = take ? ctrl.target : ctrl.next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= polymul_pkg::STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

[rtl/core/polymul_dpath.sv]
// Datapath: coefficient stores, product store, multiply-accumulate and output register.
module polymul_dpath #(
   parameter int MAX_TERMS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  polymul_pkg::ucode_type ctrl,
   output polymul_pkg::stat_type  stat,
   input  logic                   req_valid,
   input  logic [1:0]             req_op,
   input  logic [4:0]             req_coeff_index,
   input  logic signed [31:0]     req_coeff_value,
   input  logic [4:0]             req_p_degree,
   input  logic [4:0]             req_q_degree,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [5:0]             rsp_result_index,
   output logic signed [63:0]     rsp_result_value,
   output logic                   rsp_last
);

   localparam int IDX_W  = $clog2(MAX_TERMS);
   localparam int SLOTS  = 2 * MAX_TERMS - 1;
   localparam int SLOT_W = $clog2(SLOTS);

   logic signed [31:0] p_mem [MAX_TERMS];
   logic signed [31:0] q_mem [MAX_TERMS];
   logic signed [63:0] prod_mem [SLOTS];

   logic [IDX_W-1:0]   i_ff, i_in, j_ff, j_in, pd_ff, pd_in, qd_ff, qd_in;
   logic [SLOT_W-1:0]  k_ff, k_in;
   logic [SLOTS-1:0]   valid_ff, valid_in;
   logic signed [31:0] p_rd_ff, q_rd_ff;
   logic signed [63:0] prod_rd_ff, mul_ff;
   logic               prv_ff;
   logic               out_valid_ff, out_valid_in, out_last_ff;
   logic [5:0]         out_index_ff;
   logic signed [63:0] out_value_ff;

   logic               start_acc, idx_ok, load_p, load_q;
   logic [SLOT_W-1:0]  slot, rd_addr, top_slot;
   logic signed [63:0] acc_a, sum;
   logic [64:0]        sum_w;

   always_comb begin
      start_acc = req_valid && ctrl.ready && (req_op == polymul_pkg::OP_START);
      idx_ok    = {1'b0, req_coeff_index} < 6'(MAX_TERMS);
      load_p    = req_valid && ctrl.ready && idx_ok && (req_op == polymul_pkg::OP_LOAD_P);
      load_q    = req_valid && ctrl.ready && idx_ok && (req_op == polymul_pkg::OP_LOAD_Q);
      slot      = SLOT_W'(i_ff) + SLOT_W'(j_ff);
      top_slot  = SLOT_W'(pd_ff) + SLOT_W'(qd_ff);
      rd_addr   = ctrl.ord ? k_ff : slot;

      acc_a = prv_ff ? prod_rd_ff : 64'sd0;
      sum_w = {acc_a[63], acc_a} + {mul_ff[63], mul_ff};
      if (sum_w[64] != sum_w[63]) begin
         sum = sum_w[64] ? polymul_pkg::SAT_MIN : polymul_pkg::SAT_MAX;
      end else begin
         sum = sum_w[63:0];
      end

      pd_in = pd_ff;
      qd_in = qd_ff;
      i_in  = i_ff;
      j_in  = j_ff;
      k_in  = k_ff;
      valid_in = valid_ff;
      if (start_acc) begin
         pd_in = ({1'b0, req_p_degree} >= 6'(MAX_TERMS)) ? IDX_W'(MAX_TERMS - 1)
                                                          : req_p_degree[IDX_W-1:0];
         qd_in = ({1'b0, req_q_degree} >= 6'(MAX_TERMS)) ? IDX_W'(MAX_TERMS - 1)
                                                          : req_q_degree[IDX_W-1:0];
         i_in  = '0;
         j_in  = '0;
         k_in  = '0;
         valid_in = '0;
      end
      if (ctrl.acc) begin
         valid_in[slot] = 1'b1;
         if (j_ff == qd_ff) begin
            j_in = '0;
            i_in = i_ff + 1'b1;
         end else begin
            j_in = j_ff + 1'b1;
         end
      end
      if (ctrl.emit) begin
         k_in = k_ff + 1'b1;
      end

      out_valid_in = out_valid_ff;
      if (ctrl.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end

      stat.start    = req_valid && (req_op == polymul_pkg::OP_START);
      stat.mac_done = (i_ff == pd_ff) && (j_ff == qd_ff);
      stat.out_busy = out_valid_ff && !rsp_ready;
      stat.out_last = (k_ff == top_slot);
   end

   always_ff @(posedge clock) begin
      if (load_p) begin
         p_mem[req_coeff_index[IDX_W-1:0]] <= req_coeff_value;
      end
      if (load_q) begin
         q_mem[req_coeff_index[IDX_W-1:0]] <= req_coeff_value;
      end
      if (ctrl.rd) begin
         p_rd_ff <= p_mem[i_ff];
         q_rd_ff <= q_mem[j_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.acc) begin
         prod_mem[slot] <= sum;
      end
      if (ctrl.rd || ctrl.ord) begin
         prod_rd_ff <= prod_mem[rd_addr];
         prv_ff     <= valid_ff[rd_addr];
      end
      if (ctrl.mul) begin
         mul_ff <= p_rd_ff * q_rd_ff;
      end
      if (ctrl.emit) begin
         out_index_ff <= 6'(k_ff);
         out_value_ff <= prv_ff ? prod_rd_ff : 64'sd0;
         out_last_ff  <= stat.out_last;
      end
   end

   always_ff @(posedge clock) begin
      pd_ff <= pd_in;
      qd_ff <= qd_in;
      i_ff  <= i_in;
      j_ff  <= j_in;
      k_ff  <= k_in;
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_result_index = out_index_ff;
   assign rsp_result_value = out_value_ff;
   assign rsp_last         = out_last_ff;

endmodule

[rtl/core/polynomial_multiplier.sv]
// Top level of the polynomial multiplier: stream ports, sequencer and datapath.
//
//   channel | dir | tdata / tuser / tlast
//   req     | in  | coeff_index, coeff_value, p_degree, q_degree; op
//   rsp     | out | result_index, result_value; last
//
// Load items are taken only in the idle step. A start runs each of the
// (p_degree+1)*(q_degree+1) coefficient pairs through the read, multiply and
// accumulate steps, then each result coefficient through read, wait and emit steps.
// Reset clears the step counter, product valid bits and output valid flag only.
// A stalled rsp holds the wait step; req_tready is high only in the idle step.
`include "assert_macros.svh"

module polynomial_multiplier #(
   parameter int MAX_TERMS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // coeff_index[4:0], coeff_value[36:5], p_degree[41:37],
                                   // q_degree[46:42], zero[47]
   input  logic [1:0]  req_tuser,  // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // result_index[5:0], result_value[69:6], zero[71:70]
   output logic        rsp_tlast
);

   polymul_pkg::ucode_type ctrl;
   polymul_pkg::stat_type  stat;
   logic [5:0]             result_index;
   logic signed [63:0]     result_value;
   logic                   req_start;
   logic [5:0]             ctrl_actions;

   polymul_useq u_useq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   polymul_dpath #(
      .MAX_TERMS (MAX_TERMS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .stat             (stat),
      .req_valid        (req_tvalid),
      .req_op           (req_tuser),
      .req_coeff_index  (req_tdata[4:0]),
      .req_coeff_value  (req_tdata[36:5]),
      .req_p_degree     (req_tdata[41:37]),
      .req_q_degree     (req_tdata[46:42]),
      .rsp_valid        (rsp_tvalid),
      .rsp_ready        (rsp_tready),
      .rsp_result_index (result_index),
      .rsp_result_value (result_value),
      .rsp_last         (rsp_tlast)
   );

   assign req_tready   = ctrl.ready;
   assign rsp_tdata    = {2'b00, result_value, result_index};
   assign req_start    = req_tvalid && req_tready && (req_tuser == polymul_pkg::OP_START);
   assign ctrl_actions = {ctrl.ready, ctrl.rd, ctrl.mul, ctrl.acc, ctrl.ord, ctrl.emit};

   `ASSERT_IMPLIES(a_emit_slot_free, clock, reset, ctrl.emit, !stat.out_busy, "output busy")
   `ASSERT_NEXT(a_start_leaves_idle, clock, reset, req_start, !req_tready, "ready after start")
   `ASSERT_ALWAYS(a_one_action, clock, reset, $onehot0(ctrl_actions), "two actions in one step")

endmodule
